[sv/uapq_pkg.sv]
package uapq_pkg;

  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_INSERT  = 3'd0;
  localparam op_t OP_EXTRACT = 3'd1;
  localparam op_t OP_PEEK    = 3'd2;
  localparam op_t OP_FIND    = 3'd3;
  localparam op_t OP_SET_KEY = 3'd4;
  localparam op_t OP_SET_VAL = 3'd5;
  localparam op_t OP_DEL     = 3'd6;
  localparam op_t OP_CLEAR   = 3'd7;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

endpackage

[sv/uapq_ram.sv]
module uapq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/unsorted_array_max_priority_queue.sv]
// channel  | ports                                          | direction
// in       | in_valid in_ready in_op in_key in_value in_slot | item in
// out      | out_valid out_ready out_status out_key          | result out
//          | out_value out_slot out_count                   |
// insert, set key, set value, delete last, clear, and extract or peek on an empty store:
// exec, then done, which sets out_valid once the output register is free.
// peek and find scan the entries, a find stopping at its first hit; extract also moves
// the last entry into the hole. The scan reads one entry per cycle from the single
// read port of the key and value memories, through one key comparator.
// rst_n (synchronous) empties the store; no clearing pass is needed.
// a new item is taken while the previous result still waits in the output register;
// the one after that waits in the done state until the output register frees.
module unsorted_array_max_priority_queue
  import uapq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_op,
  input  logic signed [DATA_W-1:0] in_key,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [SLOT_W-1:0]        in_slot,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_key,
  output logic signed [DATA_W-1:0] out_value,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [COUNT_W-1:0]       out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_RDLAST = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_idx_r, pend_idx_nxt;
  logic              found_r, found_nxt;
  op_t               op_r, op_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] best_key_r, best_key_nxt;
  logic [DATA_W-1:0] best_val_r, best_val_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_key_r, out_key_nxt;
  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic              key_we, val_we;
  logic [AW-1:0]     key_waddr, val_waddr, raddr;
  logic [DATA_W-1:0] key_wdata, val_wdata, rd_key, rd_val;
  logic [CW-1:0]     last;
  logic              issue, key_gt, val_eq;

  uapq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (rd_key)
  );

  uapq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (rd_val)
  );

  assign last   = cnt_r - 1'b1;
  assign issue  = (state_r == S_SCAN) && (idx_r < cnt_r) && !found_r;
  assign raddr  = (state_r == S_RDLAST) ? last[AW-1:0] : idx_r[AW-1:0];
  assign key_gt = $signed(rd_key) > $signed(best_key_r);
  assign val_eq = rd_val == val_r;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_value  = out_val_r;
  assign out_slot   = out_slot_r;
  assign out_count  = out_cnt_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    pend_nxt     = issue;
    pend_idx_nxt = idx_r[AW-1:0];
    found_nxt    = found_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    slot_nxt     = slot_r;
    status_nxt   = status_r;
    best_key_nxt = best_key_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_val_nxt    = out_val_r;
    out_slot_nxt   = out_slot_r;
    out_cnt_nxt    = out_cnt_r;
    key_we    = 1'b0;
    val_we    = 1'b0;
    key_waddr = cnt_r[AW-1:0];
    val_waddr = cnt_r[AW-1:0];
    key_wdata = key_r;
    val_wdata = val_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_op;
          key_nxt  = in_key;
          val_nxt  = in_value;
          slot_nxt = in_slot;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt   = ST_OK;
        best_key_nxt = '0;
        best_val_nxt = '0;
        best_idx_nxt = '0;
        idx_nxt      = '0;
        found_nxt    = 1'b0;
        state_nxt    = S_DONE;
        case (op_r)
          OP_INSERT: begin
            if (cnt_r == CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              key_we       = 1'b1;
              val_we       = 1'b1;
              best_idx_nxt = cnt_r[AW-1:0];
              cnt_nxt      = cnt_r + 1'b1;
            end
          end
          OP_EXTRACT, OP_PEEK: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          OP_FIND: begin
            state_nxt = S_SCAN;
          end
          OP_SET_KEY, OP_SET_VAL: begin
            if (32'(slot_r) >= 32'(cnt_r)) begin
              status_nxt = ST_RANGE;
            end else begin
              key_we       = (op_r == OP_SET_KEY);
              val_we       = (op_r == OP_SET_VAL);
              key_waddr    = AW'(slot_r);
              val_waddr    = AW'(slot_r);
              best_idx_nxt = AW'(slot_r);
            end
          end
          OP_DEL: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              cnt_nxt      = last;
              best_idx_nxt = last[AW-1:0];
            end
          end
          default: begin
            cnt_nxt = '0;
          end
        endcase
      end
      S_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        // read data arrives in the cycle after its address
        if (pend_r && !found_r) begin
          if (op_r == OP_FIND) begin
            if (val_eq) begin
              found_nxt    = 1'b1;
              best_key_nxt = rd_key;
              best_val_nxt = rd_val;
              best_idx_nxt = pend_idx_r;
            end
          end else if (pend_idx_r == '0 || key_gt) begin
            best_key_nxt = rd_key;
            best_val_nxt = rd_val;
            best_idx_nxt = pend_idx_r;
          end
        end
        if (!pend_r && (idx_r >= cnt_r || found_r)) begin
          if (op_r == OP_FIND) begin
            status_nxt = found_r ? ST_OK : ST_EMPTY;
            state_nxt  = S_DONE;
          end else if (op_r == OP_EXTRACT) begin
            state_nxt = S_RDLAST;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RDLAST: begin
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        // last entry fills the hole left by the extracted one
        key_we    = 1'b1;
        val_we    = 1'b1;
        key_waddr = best_idx_r;
        val_waddr = best_idx_r;
        key_wdata = rd_key;
        val_wdata = rd_val;
        cnt_nxt   = last;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_key_nxt    = best_key_r;
          out_val_nxt    = best_val_r;
          out_slot_nxt   = SLOT_W'(best_idx_r);
          out_cnt_nxt    = COUNT_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    slot_r       <= slot_nxt;
    status_r     <= status_nxt;
    best_key_r   <= best_key_nxt;
    best_val_r   <= best_val_nxt;
    best_idx_r   <= best_idx_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_val_r    <= out_val_nxt;
    out_slot_r   <= out_slot_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

endmodule

[tb/sv/uapq_result_checker.sv]
module uapq_result_checker
  import uapq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [OP_W-1:0]          in_op,
  input  logic signed [DATA_W-1:0] in_key,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STATUS_W-1:0]      out_status,
  input  logic signed [DATA_W-1:0] out_key,
  input  logic signed [DATA_W-1:0] out_value,
  input  logic [SLOT_W-1:0]        out_slot,
  input  logic [COUNT_W-1:0]       out_count,
  output int                       outstanding,
  output int                       mismatches
);

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  key;
    logic [DATA_W-1:0]  value;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } queue_result_t;

  logic signed [DATA_W-1:0] key_mem   [CAPACITY];
  logic signed [DATA_W-1:0] value_mem [CAPACITY];
  int unsigned              n_entries;
  int unsigned              n_results;
  queue_result_t            pending_results [$];

  initial begin
    outstanding = 0;
    mismatches  = 0;
    n_entries   = 0;
    n_results   = 0;
  end

  // applies one operation to the shadow queue and returns the result it must give
  function automatic queue_result_t apply_queue_op(op_t op, logic signed [DATA_W-1:0] key,
                                                   logic signed [DATA_W-1:0] value,
                                                   logic [SLOT_W-1:0] slot);
    queue_result_t r;
    int            best;
    int            i;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (n_entries >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          key_mem[n_entries]   = key;
          value_mem[n_entries] = value;
          r.slot = n_entries[SLOT_W-1:0];
          n_entries++;
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (n_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // strict compare keeps the lowest index on ties
          best = 0;
          for (i = 1; i < n_entries; i++)
            if (key_mem[i] > key_mem[best]) best = i;
          r.key   = key_mem[best];
          r.value = value_mem[best];
          r.slot  = best[SLOT_W-1:0];
          if (op == OP_EXTRACT) begin
            key_mem[best]   = key_mem[n_entries - 1];
            value_mem[best] = value_mem[n_entries - 1];
            n_entries--;
          end
        end
      end
      OP_FIND: begin
        r.status = ST_EMPTY;
        for (i = 0; i < n_entries; i++) begin
          if (value_mem[i] == value) begin
            r.status = ST_OK;
            r.key    = key_mem[i];
            r.value  = value_mem[i];
            r.slot   = i[SLOT_W-1:0];
            break;
          end
        end
      end
      OP_SET_KEY, OP_SET_VAL: begin
        if (slot >= n_entries) begin
          r.status = ST_RANGE;
        end else begin
          if (op == OP_SET_KEY) key_mem[slot] = key;
          else value_mem[slot] = value;
          r.slot = slot;
        end
      end
      OP_DEL: begin
        if (n_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          n_entries--;
          r.slot = n_entries[SLOT_W-1:0];
        end
      end
      OP_CLEAR: n_entries = 0;
    endcase
    r.count = n_entries[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    mismatches++;
    $display("mismatch in result %0d, %s: got %0h, expected %0h", n_results, what, got, want);
  endtask

  always @(posedge clk) begin : monitor
    queue_result_t want;
    if (!rst_n) begin
      n_entries = 0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("transfer with no result outstanding", '0, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
          if (out_key !== want.key) report_mismatch("key", out_key, want.key);
          if (out_value !== want.value) report_mismatch("value", out_value, want.value);
          if (out_slot !== want.slot)
            report_mismatch("slot", DATA_W'(out_slot), DATA_W'(want.slot));
          if (out_count !== want.count)
            report_mismatch("count", DATA_W'(out_count), DATA_W'(want.count));
        end
        n_results++;
      end
      if (in_valid && in_ready)
        pending_results.push_back(apply_queue_op(in_op, in_key, in_value, in_slot));
    end
    outstanding = pending_results.size();
  end

endmodule

[tb/sv/tb_unsorted_array_max_priority_queue.sv]
module tb_unsorted_array_max_priority_queue;
  import uapq_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_ITEMS = 960;
  localparam int QUIET_ITEMS  = 150;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 3000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          in_op;
  logic signed [DATA_W-1:0] in_key;
  logic signed [DATA_W-1:0] in_value;
  logic [SLOT_W-1:0]        in_slot;
  logic                     out_valid;
  logic                     out_ready;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_key;
  logic signed [DATA_W-1:0] out_value;
  logic [SLOT_W-1:0]        out_slot;
  logic [COUNT_W-1:0]       out_count;

  int outstanding;
  int mismatches;
  int idle_cycles = 0;
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;

  unsorted_array_max_priority_queue #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_key    (in_key),
    .in_value  (in_value),
    .in_slot   (in_slot),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_key   (out_key),
    .out_value (out_value),
    .out_slot  (out_slot),
    .out_count (out_count)
  );

  uapq_result_checker #(
    .CAPACITY(CAPACITY)
  ) result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_key     (in_key),
    .in_value   (in_value),
    .in_slot    (in_slot),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_key    (out_key),
    .out_value  (out_value),
    .out_slot   (out_slot),
    .out_count  (out_count),
    .outstanding(outstanding),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // small pools make ties and find hits common
  function automatic logic [DATA_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return DATA_W'($urandom_range(0, 3)) - DATA_W'(2);
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 1)) return DATA_W'($urandom_range(0, 7));
    return $urandom();
  endfunction

  function automatic op_t pick_op(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (r < (grow ? 45 : 20)) return OP_INSERT;
    r = $urandom_range(0, 99);
    if (r < 30) return OP_EXTRACT;
    if (r < 42) return OP_PEEK;
    if (r < 62) return OP_FIND;
    if (r < 76) return OP_SET_KEY;
    if (r < 90) return OP_SET_VAL;
    if (r < 98) return OP_DEL;
    return OP_CLEAR;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(op_t op, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value,
                           logic [SLOT_W-1:0] slot);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_op    = op;
    in_key   = key;
    in_value = value;
    in_slot  = slot;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int  n;
    bit  grow;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_op    = OP_INSERT;
    in_key   = '0;
    in_value = '0;
    in_slot  = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // empty store: every failing path
    send_item(OP_PEEK,    '0, '0, 4'd0);
    send_item(OP_EXTRACT, '0, '0, 4'd0);
    send_item(OP_DEL,     '0, '0, 4'd0);
    send_item(OP_FIND,    '0, '0, 4'd0);
    send_item(OP_SET_KEY, 32'h1234_5678, '0, 4'd0);
    send_item(OP_SET_VAL, '0, 32'h1234_5678, 4'd15);
    // key extremes with a tie on the largest key
    send_item(OP_INSERT, 32'h7fff_ffff, 32'h0000_0000, 4'd0);
    send_item(OP_INSERT, 32'h8000_0000, 32'hffff_ffff, 4'd0);
    send_item(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 4'd0);
    send_item(OP_INSERT, 32'h0000_0000, 32'h8000_0000, 4'd0);
    send_item(OP_PEEK,   '0, '0, 4'd0);
    send_item(OP_FIND,   '0, 32'hffff_ffff, 4'd0);
    send_item(OP_FIND,   '0, 32'd12345, 4'd0);
    send_item(OP_SET_KEY, 32'h8000_0000, '0, 4'd3);
    send_item(OP_SET_VAL, '0, 32'h8000_0000, 4'd2);
    send_item(OP_FIND,   '0, 32'h8000_0000, 4'd0);
    send_item(OP_SET_KEY, 32'h7fff_ffff, '0, 4'd4);
    send_item(OP_EXTRACT, '0, '0, 4'd0);
    send_item(OP_EXTRACT, '0, '0, 4'd0);
    send_item(OP_DEL,    '0, '0, 4'd0);
    send_item(OP_CLEAR,  '0, '0, 4'd0);
    send_item(OP_CLEAR,  '0, '0, 4'd0);

    // fill to capacity, one insert past full, then touch the top slot
    for (n = 0; n <= CAPACITY; n++)
      send_item(OP_INSERT, pick_key(), pick_value(), 4'($urandom_range(0, 15)));
    send_item(OP_SET_KEY, pick_key(), pick_value(), 4'd15);
    send_item(OP_SET_VAL, pick_key(), pick_value(), 4'd15);
    send_item(OP_EXTRACT, '0, '0, 4'd0);

    grow = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) grow = (n / 40) % 3 != 2;
      if (n == 300) hold_req = 1'b1;
      if (n == 600) begin
        // drain everything before going on
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_item(pick_op(grow), pick_key(), pick_value(), 4'($urandom_range(0, 15)));
    end

    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off so the block backs up and stalls its input
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 6);
        out_ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
